>>> src/rotation_matrix_to_quaternion_defines.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by src/rotation_matrix_to_quaternion.sv; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication
`define RMQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

   localparam int THR_W = 12;
   localparam logic [THR_W-1:0] NEAR_ZERO_RESET = 12'd1;

   // component codes
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;
   localparam logic [1:0] COMP_W = 2'd3;

   // per-request control that rides along the pipeline
   typedef struct packed {
      logic       degen;
      logic [1:0] dom;    // dominant component (COMP_W on the trace path)
      logic [2:0] neg;    // sign of each divider lane
   } ctl_type;

   // cyclic successor x->y->z->x
   function automatic logic [1:0] next_comp(input logic [1:0] c);
      logic [1:0] r;
      unique case (c)
         COMP_X:  r = COMP_Y;
         COMP_Y:  r = COMP_Z;
         COMP_Z:  r = COMP_X;
         default: r = COMP_X;
      endcase
      return r;
   endfunction

endpackage

>>> src/rmq_front.sv
// Front end: near-zero test, path select, radicand and numerators (2 stages).
// Depends on rmq_pkg.
module rmq_front #(
   parameter int DW = 16,
   parameter int FB = 12,
   localparam int TW = ((DW > FB) ? DW : FB + 1) + 3,
   localparam int RW = TW - 1 + FB,
   localparam int NW = DW + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [11:0][DW-1:0]       in_m,
   input  logic [rmq_pkg::THR_W-1:0] thr,
   output logic                      out_valid,
   output rmq_pkg::ctl_type          out_ctl,
   output logic [RW-1:0]             out_rad,
   output logic [2:0][NW-1:0]        out_mag
);
   import rmq_pkg::*;

   localparam logic signed [TW-1:0] ONE_T = TW'(1) << FB;

   // stage 1
   logic [11:0][DW-1:0] m_ff;
   logic                v1_ff, degen1_ff, trpos1_ff;
   logic [1:0]          i1_ff;
   logic [11:0]         big;
   logic                degen_in, trpos_in;
   logic [1:0]          i_in;

   // stage 2
   logic                v2_ff;
   ctl_type             ctl_ff, ctl_in;
   logic [RW-1:0]       rad_ff, rad_in;
   logic [2:0][NW-1:0]  mag_ff, mag_in;

   function automatic logic signed [TW-1:0] el(input logic [1:0] r, input logic [1:0] c);
      logic signed [DW-1:0] v;
      v = signed'(m_ff[{r, c}]);
      return TW'(v);
   endfunction

   always_comb begin
      logic signed [DW+1:0] tr;
      logic signed [DW-1:0] d0, d1, d2, dsel;
      logic [DW:0]          a;
      for (int e = 0; e < 12; e++) begin
         a = (DW+1)'(signed'(in_m[e]));
         if (a[DW]) begin
            a = -a;
         end
         big[e] = a > (DW+1)'(thr);
      end
      degen_in = (big[3:0] == '0) || (big[7:4] == '0) || (big[11:8] == '0);
      d0 = signed'(in_m[0]);
      d1 = signed'(in_m[5]);
      d2 = signed'(in_m[10]);
      tr = (DW+2)'(d0) + (DW+2)'(d1) + (DW+2)'(d2);
      trpos_in = tr > 0;
      i_in = COMP_X;
      dsel = d0;
      if (d1 > d0) begin
         i_in = COMP_Y;
         dsel = d1;
      end
      if (d2 > dsel) begin
         i_in = COMP_Z;
      end
   end

   always_comb begin
      logic [1:0]              j, k;
      logic signed [TW-1:0]    t;
      logic signed [NW-1:0]    n [3];
      j = next_comp(i1_ff);
      k = next_comp(j);
      if (trpos1_ff) begin
         t = el(2'd0, 2'd0) + el(2'd1, 2'd1) + el(2'd2, 2'd2) + ONE_T;
         n[0] = NW'(el(2'd1, 2'd2) - el(2'd2, 2'd1));
         n[1] = NW'(el(2'd2, 2'd0) - el(2'd0, 2'd2));
         n[2] = NW'(el(2'd0, 2'd1) - el(2'd1, 2'd0));
         ctl_in.dom = COMP_W;
      end else begin
         t = el(i1_ff, i1_ff) - el(j, j) - el(k, k) + ONE_T;
         if (t < 1) begin
            t = TW'(1);
         end
         n[0] = NW'(el(j, k) - el(k, j));
         n[1] = NW'(el(i1_ff, j) + el(j, i1_ff));
         n[2] = NW'(el(i1_ff, k) + el(k, i1_ff));
         ctl_in.dom = i1_ff;
      end
      ctl_in.degen = degen1_ff;
      for (int l = 0; l < 3; l++) begin
         ctl_in.neg[l] = n[l][NW-1];
         mag_in[l]     = n[l][NW-1] ? NW'(-n[l]) : NW'(n[l]);
      end
      rad_in = RW'(t[TW-2:0]) << FB;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      m_ff      <= in_m;
      degen1_ff <= degen_in;
      trpos1_ff <= trpos_in;
      i1_ff     <= i_in;
      ctl_ff    <= ctl_in;
      rad_ff    <= rad_in;
      mag_ff    <= mag_in;
   end

   assign out_valid = v2_ff;
   assign out_ctl   = ctl_ff;
   assign out_rad   = rad_ff;
   assign out_mag   = mag_ff;

endmodule

>>> src/rmq_isqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on rmq_pkg (house import only).
module rmq_isqrt #(
   parameter int RW   = 30,
   parameter int SB_W = 8,
   localparam int SQ  = (RW + 1) / 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [RW-1:0]   in_rad,
   input  logic [SB_W-1:0] in_side,
   output logic            out_valid,
   output logic [SQ-1:0]   out_root,
   output logic [SB_W-1:0] out_side
);
   import rmq_pkg::*;

   localparam int PW = 2 * SQ;

   logic [PW-1:0]   rad_ff  [SQ];
   logic [SQ:0]     rem_ff  [SQ];
   logic [SQ-1:0]   root_ff [SQ];
   logic [SB_W-1:0] side_ff [SQ];
   logic [SQ-1:0]   vld_ff;

   for (genvar s = 0; s < SQ; s++) begin : g_stage
      logic [PW-1:0]   rad_w;
      logic [SQ:0]     rem_w;
      logic [SQ-1:0]   root_w;
      logic [SB_W-1:0] side_w;
      logic            vld_w;
      logic [SQ+1:0]   sh_w, trial_w;
      logic            ge_w;

      if (s == 0) begin : g_first
         assign rad_w  = PW'(in_rad);
         assign rem_w  = '0;
         assign root_w = '0;
         assign side_w = in_side;
         assign vld_w  = in_valid;
      end else begin : g_rest
         assign rad_w  = rad_ff[s-1];
         assign rem_w  = rem_ff[s-1];
         assign root_w = root_ff[s-1];
         assign side_w = side_ff[s-1];
         assign vld_w  = vld_ff[s-1];
      end

      assign sh_w    = {rem_w[SQ-1:0], rad_w[PW-1 -: 2]};
      assign trial_w = {root_w, 2'b01};
      assign ge_w    = sh_w >= trial_w;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_w;
         end
         rad_ff[s]  <= rad_w << 2;
         rem_ff[s]  <= ge_w ? (SQ+1)'(sh_w - trial_w) : (SQ+1)'(sh_w);
         root_ff[s] <= {root_w[SQ-2:0], ge_w};
         side_ff[s] <= side_w;
      end
   end

   assign out_valid = vld_ff[SQ-1];
   assign out_root  = root_ff[SQ-1];
   assign out_side  = side_ff[SQ-1];

endmodule

>>> src/rmq_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Depends on rmq_pkg for the control struct.
module rmq_div #(
   parameter int ND   = 30,
   parameter int DD   = 16,
   parameter int SB_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [2:0][ND-1:0]   in_num,
   input  logic [DD-1:0]        in_den,
   input  rmq_pkg::ctl_type     in_ctl,
   input  logic [SB_W-1:0]      in_side,
   output logic                 out_valid,
   output logic [2:0][ND-1:0]   out_quot,
   output rmq_pkg::ctl_type     out_ctl,
   output logic [SB_W-1:0]      out_side
);
   import rmq_pkg::*;

   logic [2:0][ND-1:0] nq_ff   [ND];
   logic [2:0][DD-1:0] rem_ff  [ND];
   logic [DD-1:0]      den_ff  [ND];
   ctl_type            ctl_ff  [ND];
   logic [SB_W-1:0]    side_ff [ND];
   logic [ND-1:0]      vld_ff;

   for (genvar s = 0; s < ND; s++) begin : g_stage
      logic [2:0][ND-1:0] nq_w, nq_n;
      logic [2:0][DD-1:0] rem_w, rem_n;
      logic [DD-1:0]      den_w;
      ctl_type            ctl_w;
      logic [SB_W-1:0]    side_w;
      logic               vld_w;

      if (s == 0) begin : g_first
         assign nq_w   = in_num;
         assign rem_w  = '0;
         assign den_w  = in_den;
         assign ctl_w  = in_ctl;
         assign side_w = in_side;
         assign vld_w  = in_valid;
      end else begin : g_rest
         assign nq_w   = nq_ff[s-1];
         assign rem_w  = rem_ff[s-1];
         assign den_w  = den_ff[s-1];
         assign ctl_w  = ctl_ff[s-1];
         assign side_w = side_ff[s-1];
         assign vld_w  = vld_ff[s-1];
      end

      always_comb begin
         logic [DD:0] sh;
         logic        ge;
         for (int l = 0; l < 3; l++) begin
            sh       = {rem_w[l], nq_w[l][ND-1]};
            ge       = sh >= {1'b0, den_w};
            rem_n[l] = ge ? DD'(sh - {1'b0, den_w}) : DD'(sh);
            nq_n[l]  = {nq_w[l][ND-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_w;
         end
         nq_ff[s]   <= nq_n;
         rem_ff[s]  <= rem_n;
         den_ff[s]  <= den_w;
         ctl_ff[s]  <= ctl_w;
         side_ff[s] <= side_w;
      end
   end

   assign out_valid = vld_ff[ND-1];
   assign out_quot  = nq_ff[ND-1];
   assign out_ctl   = ctl_ff[ND-1];
   assign out_side  = side_ff[ND-1];

endmodule

>>> src/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd), fixed point, deep pipeline.
// Depends on rmq_pkg, rmq_front, rmq_isqrt, rmq_div and the defines header.
//
//  channel   ports                              handshake
//  --------  ---------------------------------  ---------------------------
//  request   req_m00 .. req_m23                 start & !busy
//  result    rsp_quat_x/y/z/w, rsp_degenerate   rsp_valid, one-cycle strobe
//  config    csr_data (near-zero threshold)     csr_valid & csr_ready
//
// One request per cycle. Requests pass through the front end, the square-root
// pipe (SQ = one stage per root bit), the dividend setup register, the divider
// pipe (ND = one stage per quotient bit) and the output register.
// busy is never raised and csr_ready is always high. Synchronous reset
// clears the valid chain and loads the threshold with 1. The receiver
// cannot stall, so nothing ever backs up.
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS  = 12,
   parameter int DATA_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [DATA_WIDTH-1:0]       req_m00,
   input  logic [DATA_WIDTH-1:0]       req_m01,
   input  logic [DATA_WIDTH-1:0]       req_m02,
   input  logic [DATA_WIDTH-1:0]       req_m03,
   input  logic [DATA_WIDTH-1:0]       req_m10,
   input  logic [DATA_WIDTH-1:0]       req_m11,
   input  logic [DATA_WIDTH-1:0]       req_m12,
   input  logic [DATA_WIDTH-1:0]       req_m13,
   input  logic [DATA_WIDTH-1:0]       req_m20,
   input  logic [DATA_WIDTH-1:0]       req_m21,
   input  logic [DATA_WIDTH-1:0]       req_m22,
   input  logic [DATA_WIDTH-1:0]       req_m23,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rmq_pkg::THR_W-1:0]   csr_data,
   output logic                        rsp_valid,
   output logic [DATA_WIDTH-1:0]       rsp_quat_x,
   output logic [DATA_WIDTH-1:0]       rsp_quat_y,
   output logic [DATA_WIDTH-1:0]       rsp_quat_z,
   output logic [DATA_WIDTH-1:0]       rsp_quat_w,
   output logic                        rsp_degenerate
);
   import rmq_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   // radicand: t fits TW-1 bits unsigned, shifted left by FB
   localparam int TW = ((DW > FB) ? DW : FB + 1) + 3;
   localparam int RW = TW - 1 + FB;
   localparam int SQ = (RW + 1) / 2;
   // numerator magnitude, dividend (mag << FB) + r, divisor 2r
   localparam int NW = DW + 1;
   localparam int ND = NW + FB + 1;
   localparam int DD = SQ + 1;
   localparam int CW = $bits(ctl_type);

   localparam logic [ND-1:0] MAG_MAX = ND'({1'b0, {(DW-1){1'b1}}});
   localparam logic [ND-1:0] MAG_MIN = ND'({1'b1, {(DW-1){1'b0}}});
   localparam logic [ND-1:0] ONE_MAG = ND'(1) << FB;

   // threshold register
   logic [THR_W-1:0] thr_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= NEAR_ZERO_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   // front end
   logic [11:0][DW-1:0] req_m;
   logic                fe_valid;
   ctl_type             fe_ctl;
   logic [RW-1:0]       fe_rad;
   logic [2:0][NW-1:0]  fe_mag;

   assign req_m = {req_m23, req_m22, req_m21, req_m20,
                   req_m13, req_m12, req_m11, req_m10,
                   req_m03, req_m02, req_m01, req_m00};

   rmq_front #(.DW(DW), .FB(FB)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_m      (req_m),
      .thr       (thr_ff),
      .out_valid (fe_valid),
      .out_ctl   (fe_ctl),
      .out_rad   (fe_rad),
      .out_mag   (fe_mag)
   );

   // square root; control and numerator magnitudes ride along
   logic                  sq_valid;
   logic [SQ-1:0]         sq_root;
   logic [CW+3*NW-1:0]    sq_side;
   ctl_type               sq_ctl;
   logic [2:0][NW-1:0]    sq_mag;

   rmq_isqrt #(.RW(RW), .SB_W(CW + 3*NW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_rad    (fe_rad),
      .in_side   ({fe_ctl, fe_mag}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign {sq_ctl, sq_mag} = sq_side;

   // dividend setup: (mag << FB) + r gives round half away from zero
   logic               pre_valid_ff;
   logic [2:0][ND-1:0] pre_num_ff;
   logic [DD-1:0]      pre_den_ff;
   ctl_type            pre_ctl_ff;
   logic [SQ-1:0]      pre_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= sq_valid;
      end
      for (int l = 0; l < 3; l++) begin
         pre_num_ff[l] <= (ND'(sq_mag[l]) << FB) + ND'(sq_root);
      end
      pre_den_ff  <= {sq_root, 1'b0};
      pre_ctl_ff  <= sq_ctl;
      pre_root_ff <= sq_root;
   end

   // divider
   logic               dv_valid;
   logic [2:0][ND-1:0] dv_quot;
   ctl_type            dv_ctl;
   logic [SQ-1:0]      dv_root;

   rmq_div #(.ND(ND), .DD(DD), .SB_W(SQ)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid_ff),
      .in_num    (pre_num_ff),
      .in_den    (pre_den_ff),
      .in_ctl    (pre_ctl_ff),
      .in_side   (pre_root_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_ctl   (dv_ctl),
      .out_side  (dv_root)
   );

   // saturate a sign-magnitude value to the signed output range
   function automatic logic [DW-1:0] sat_fn(input logic [ND-1:0] mag, input logic neg);
      logic [DW-1:0] r;
      if (!neg) begin
         r = (mag > MAG_MAX) ? MAG_MAX[DW-1:0] : mag[DW-1:0];
      end else begin
         r = (mag > MAG_MIN) ? MAG_MIN[DW-1:0] : DW'(~mag[DW-1:0] + 1'b1);
      end
      return r;
   endfunction

   // route lanes to components, then saturate
   logic [3:0][DW-1:0] q_in;

   always_comb begin
      logic [3:0][ND-1:0] cm;
      logic [3:0]         cn;
      logic [ND-1:0]      dmag;
      logic [1:0]         j, k;
      dmag = ND'((ND'(dv_root) + 1'b1) >> 1);
      j    = next_comp(dv_ctl.dom);
      k    = next_comp(j);
      cm   = '0;
      cn   = '0;
      if (dv_ctl.dom == COMP_W) begin
         cm[COMP_X] = dv_quot[0];
         cn[COMP_X] = dv_ctl.neg[0];
         cm[COMP_Y] = dv_quot[1];
         cn[COMP_Y] = dv_ctl.neg[1];
         cm[COMP_Z] = dv_quot[2];
         cn[COMP_Z] = dv_ctl.neg[2];
         cm[COMP_W] = dmag;
      end else begin
         cm[COMP_W]     = dv_quot[0];
         cn[COMP_W]     = dv_ctl.neg[0];
         cm[j]          = dv_quot[1];
         cn[j]          = dv_ctl.neg[1];
         cm[k]          = dv_quot[2];
         cn[k]          = dv_ctl.neg[2];
         cm[dv_ctl.dom] = dmag;
         cn[dv_ctl.dom] = 1'b0;
      end
      if (dv_ctl.degen) begin
         cm = '0;
         cn = '0;
         cm[COMP_W] = ONE_MAG;
      end
      for (int c = 0; c < 4; c++) begin
         q_in[c] = sat_fn(cm[c], cn[c]);
      end
   end

   // output register
   logic               rsp_valid_ff;
   logic               rsp_degen_ff;
   logic [3:0][DW-1:0] rsp_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_degen_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
         rsp_degen_ff <= dv_valid && dv_ctl.degen;
      end
      rsp_q_ff <= q_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_quat_x     = rsp_q_ff[COMP_X];
   assign rsp_quat_y     = rsp_q_ff[COMP_Y];
   assign rsp_quat_z     = rsp_q_ff[COMP_Z];
   assign rsp_quat_w     = rsp_q_ff[COMP_W];

   `RMQ_ASSERT_IMP(a_degen_identity, clock, reset, rsp_valid && rsp_degenerate, rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0, "degenerate result is not identity")
   `RMQ_ASSERT_IMP(a_degen_strobe, clock, reset, !rsp_valid, !rsp_degenerate, "degenerate flag without strobe")
   `RMQ_ASSERT_NXT(a_thr_write, clock, reset, csr_valid && csr_ready, thr_ff == $past(csr_data), "threshold write lost")

endmodule
